/* rtl/core/bf3_pkg.sv */
// Shared constants, types and codes for the 3x3 clipped box filter.
// No dependencies; every other file of the block refers to it by scoped names.
package bf3_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = ADDR_W;
    localparam int PIX_W      = 8;
    localparam int WID_W      = 8;
    localparam int HGT_W      = 12;
    localparam int XW         = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;
    localparam int RW         = HGT_W + 1;
    localparam int LAG_W      = $clog2(MAX_WIDTH + 2);
    localparam int SUM_W      = $clog2(9 * 255 + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WID_W-1:0] FRAME_WIDTH_RST  = 8'd80;
    localparam logic [HGT_W-1:0] FRAME_HEIGHT_RST = 12'd21;
    localparam logic [WID_W-1:0] MIN_WIDTH        = 8'd3;
    localparam logic [HGT_W-1:0] MIN_HEIGHT       = 12'd3;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // floor(x/d) == (x * ceil(2^16/d)) >> 16 for every x below 2^15
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_DIV6 = 14'd10923;
    localparam logic [RECIP_W-1:0] RECIP_DIV9 = 14'd7282;

    typedef enum logic [1:0] {
        DIV_BY4,
        DIV_BY6,
        DIV_BY9
    } t_div_sel;

    // which neighbors of the emitted cell lie inside the frame, and whether it ends the frame
    typedef struct packed {
        logic has_left;
        logic has_right;
        logic has_up;
        logic has_down;
        logic eof;
    } t_emit;

    typedef struct packed {
        logic             is_push;
        logic             fire;
        logic [PIX_W-1:0] value;
        t_emit            emit;
    } t_s1_info;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_div_sel         sel;
        logic             eof;
    } t_sum;

endpackage

/* rtl/core/bf3_in_if.sv */
// Request channel of the box filter: valid/ready plus func and cell_value.
// Depends on bf3_pkg.
interface bf3_in_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [bf3_pkg::PIX_W-1:0] cell_value;

    modport source (output valid, output func, output cell_value, input ready);
    modport sink   (input valid, input func, input cell_value, output ready);
endinterface

/* rtl/core/bf3_out_if.sv */
// Result channel of the box filter: valid/ready plus smoothed_value and end_of_frame.
// Depends on bf3_pkg.
interface bf3_out_if;
    logic                      valid;
    logic                      ready;
    logic [bf3_pkg::PIX_W-1:0] smoothed_value;
    logic                      end_of_frame;

    modport source (output valid, output smoothed_value, output end_of_frame, input ready);
    modport sink   (input valid, input smoothed_value, input end_of_frame, output ready);
endinterface

/* rtl/core/box_filter_3x3_clipped_unit.sv */
// 3x3 clipped box filter on a raster stream; uses bf3_pkg, bf3_in_if, bf3_out_if.
// A result passes the S1, S2 and S3 registers and then the output register.
// Throughput: one request per cycle, pushes and flushes alike; the two line stores
// take at most one read and one write per cycle. Ready drops only when the output backs up.
// Reset (sync, active low): counters, lag/drain state and stage valids clear, frame
// size returns to 80x21; line stores are not cleared and need no clearing pass.
module box_filter_3x3_clipped_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bf3_in_if.sink                         i_req,
    bf3_out_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Pipeline:
    //   S1  request stage: counters update, line-store read issued (bf3_ctrl)
    //   S2  window shift + line-store write-back (bf3_window / bf3_line_store)
    //   S3  clipped 3x3 sum registered with its divisor select
    //   out reciprocal divide into the output register (bf3_div)
    // Each stage moves when the next one is empty or moving, so bubbles collapse
    // and a waiting result does not block new requests until the stages fill.

    logic                      accept;
    logic                      s1_valid, s1_take;
    bf3_pkg::t_s1_info         s1_info;
    bf3_pkg::t_rd_req          rd_req;
    logic [bf3_pkg::PIX_W-1:0] ls_older, ls_newer;
    logic                      s3_valid, out_free;
    bf3_pkg::t_sum             s3_sum;

    assign i_req.ready = !s1_valid || s1_take;
    assign accept      = i_req.valid && i_req.ready;

    bf3_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_func       (i_req.func),
        .i_cell_value (i_req.cell_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_s1_take    (s1_take),
        .o_s1_valid   (s1_valid),
        .o_s1         (s1_info),
        .o_rd         (rd_req)
    );

    // only pushes write back; flushes read the rows above and leave them alone
    bf3_line_store u_line_store (
        .i_clk      (i_clk),
        .i_rd       (rd_req),
        .i_wr_en    (s1_take && s1_info.is_push),
        .i_wr_value (s1_info.value),
        .o_older    (ls_older),
        .o_newer    (ls_newer)
    );

    bf3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1_info),
        .i_older    (ls_older),
        .i_newer    (ls_newer),
        .i_out_free (out_free),
        .o_s1_take  (s1_take),
        .o_s3_valid (s3_valid),
        .o_s3       (s3_sum)
    );

    bf3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .i_sum   (s3_sum),
        .i_ready (o_res.ready),
        .o_free  (out_free),
        .o_valid (o_res.valid),
        .o_value (o_res.smoothed_value),
        .o_eof   (o_res.end_of_frame)
    );

endmodule

/* rtl/core/bf3_ctrl.sv */
// Request stage: frame registers, raster counters, lag/drain bookkeeping and
// line-store read issue. Depends on bf3_pkg.
module bf3_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_func,
    input  logic [bf3_pkg::PIX_W-1:0]          i_cell_value,
    input  logic                               i_cfg_we,
    input  logic [bf3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bf3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s1_take,
    output logic                               o_s1_valid,
    output bf3_pkg::t_s1_info                  o_s1,
    output bf3_pkg::t_rd_req                   o_rd
);

    logic [bf3_pkg::WID_W-1:0] r_frame_width;
    logic [bf3_pkg::HGT_W-1:0] r_frame_height;
    logic [bf3_pkg::COL_W-1:0] r_in_col,  n_in_col;
    logic [bf3_pkg::HGT_W-1:0] r_in_row,  n_in_row;
    logic [bf3_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic [bf3_pkg::HGT_W-1:0] r_out_row, n_out_row;
    logic [bf3_pkg::LAG_W-1:0] r_lag, n_lag;
    logic [bf3_pkg::LAG_W-1:0] r_drain, n_drain;
    logic                      r_begun, n_begun;
    logic                      r_s1_valid;
    bf3_pkg::t_s1_info         r_s1, n_s1;

    logic [bf3_pkg::WID_W-1:0] eff_w;
    logic [bf3_pkg::HGT_W-1:0] eff_h;
    logic [bf3_pkg::XW-1:0]    w_x, in_col_p1, out_col_p1;
    logic [bf3_pkg::RW-1:0]    h_x, in_row_p1, out_row_p1;
    logic [bf3_pkg::COL_W-1:0] out_col_v;
    logic [bf3_pkg::HGT_W-1:0] out_row_v;
    logic [bf3_pkg::LAG_W-1:0] lag_v, drain_v;
    logic                      enter, do_emit, fire;

    // clamp the width between the minimum and what the line stores can hold, and the height to the minimum
    always_comb begin
        if (r_frame_width < bf3_pkg::MIN_WIDTH) begin
            eff_w = bf3_pkg::MIN_WIDTH;
        end else if (r_frame_width > bf3_pkg::WID_W'(bf3_pkg::MAX_WIDTH)) begin
            eff_w = bf3_pkg::WID_W'(bf3_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_frame_width;
        end
        eff_h = (r_frame_height < bf3_pkg::MIN_HEIGHT) ? bf3_pkg::MIN_HEIGHT : r_frame_height;
        w_x   = bf3_pkg::XW'(eff_w);
        h_x   = bf3_pkg::RW'(eff_h);
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_begun   = r_begun;
        out_col_v = r_out_col;
        out_row_v = r_out_row;
        lag_v     = r_lag;
        drain_v   = r_drain;
        n_lag     = r_lag;
        n_drain   = r_drain;
        enter     = 1'b0;
        do_emit   = 1'b0;
        fire      = 1'b0;
        o_rd.addr = r_in_col;
        in_col_p1 = bf3_pkg::XW'(r_in_col) + bf3_pkg::XW'(1);
        in_row_p1 = bf3_pkg::RW'(r_in_row) + bf3_pkg::RW'(1);

        if (i_accept) begin
            if (i_func == bf3_pkg::FUNC_FLUSH) begin
                // nothing pending: the flush is dropped here
                if (r_drain != '0) begin
                    enter   = 1'b1;
                    fire    = 1'b1;
                    do_emit = 1'b1;
                    n_lag   = (r_lag != '0) ? r_lag - bf3_pkg::LAG_W'(1) : r_lag;
                    n_drain = r_drain - bf3_pkg::LAG_W'(1);
                    n_begun = (r_drain != bf3_pkg::LAG_W'(1));
                end
            end else begin
                // a push after a partial drain abandons the old frame's tail
                if (r_begun && r_drain != '0) begin
                    lag_v     = '0;
                    drain_v   = '0;
                    out_col_v = '0;
                    out_row_v = '0;
                end
                n_begun = 1'b0;
                enter   = 1'b1;
                fire    = bf3_pkg::XW'(lag_v) >= w_x + bf3_pkg::XW'(1);
                do_emit = fire;
                n_lag   = fire ? lag_v : lag_v + bf3_pkg::LAG_W'(1);
                n_drain = (fire && drain_v != '0) ? drain_v - bf3_pkg::LAG_W'(1) : drain_v;
                if (in_col_p1 >= w_x) begin
                    n_in_col = '0;
                    n_in_row = (in_row_p1 >= h_x) ? '0 : in_row_p1[bf3_pkg::HGT_W-1:0];
                    if (in_row_p1 >= h_x) begin
                        n_drain = n_lag;
                    end
                end else begin
                    n_in_col = in_col_p1[bf3_pkg::COL_W-1:0];
                end
            end
        end

        out_col_p1 = bf3_pkg::XW'(out_col_v) + bf3_pkg::XW'(1);
        out_row_p1 = bf3_pkg::RW'(out_row_v) + bf3_pkg::RW'(1);
        n_out_col  = out_col_v;
        n_out_row  = out_row_v;

        if (i_accept && i_func == bf3_pkg::FUNC_FLUSH) begin
            o_rd.addr = (out_col_p1 >= w_x) ? '0 : out_col_p1[bf3_pkg::COL_W-1:0];
        end

        if (do_emit) begin
            if (out_col_p1 >= w_x) begin
                n_out_col = '0;
                n_out_row = (out_row_p1 >= h_x) ? '0 : out_row_p1[bf3_pkg::HGT_W-1:0];
            end else begin
                n_out_col = out_col_p1[bf3_pkg::COL_W-1:0];
            end
        end

        n_s1.is_push        = (i_func == bf3_pkg::FUNC_PUSH);
        n_s1.fire           = fire;
        n_s1.value          = i_cell_value;
        n_s1.emit.has_left  = (out_col_v != '0);
        n_s1.emit.has_right = (out_col_p1 < w_x);
        n_s1.emit.has_up    = (out_row_v != '0);
        n_s1.emit.has_down  = (out_row_p1 < h_x);
        n_s1.emit.eof       = (out_row_p1 == h_x) && (out_col_p1 == w_x);

        o_rd.en = enter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bf3_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bf3_pkg::FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_lag          <= '0;
            r_drain        <= '0;
            r_begun        <= 1'b0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == bf3_pkg::CFG_FRAME_WIDTH) begin
                    r_frame_width <= i_cfg_data[bf3_pkg::WID_W-1:0];
                end
                if (i_cfg_index == bf3_pkg::CFG_FRAME_HEIGHT) begin
                    r_frame_height <= i_cfg_data[bf3_pkg::HGT_W-1:0];
                end
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lag     <= n_lag;
            r_drain   <= n_drain;
            r_begun   <= n_begun;
            if (enter) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enter) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    a_drain_within_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain <= r_lag)
        else $error("drain count exceeds lag count");

    a_idle_flush_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_func == bf3_pkg::FUNC_FLUSH && r_drain == '0) |=> !r_s1_valid)
        else $error("flush with nothing pending entered the pipeline");

endmodule

/* rtl/core/bf3_line_store.sv */
// Two 8-bit line stores (older and newer row) with registered read and
// same-address forwarding from the write stage. Depends on bf3_pkg.
module bf3_line_store (
    input  logic                       i_clk,
    input  bf3_pkg::t_rd_req           i_rd,
    input  logic                       i_wr_en,
    input  logic [bf3_pkg::PIX_W-1:0]  i_wr_value,
    output logic [bf3_pkg::PIX_W-1:0]  o_older,
    output logic [bf3_pkg::PIX_W-1:0]  o_newer
);

    logic [bf3_pkg::PIX_W-1:0]  mem_older [bf3_pkg::MAX_WIDTH];
    logic [bf3_pkg::PIX_W-1:0]  mem_newer [bf3_pkg::MAX_WIDTH];
    logic [bf3_pkg::ADDR_W-1:0] r_addr;
    logic [bf3_pkg::PIX_W-1:0]  r_q_older, r_q_newer;
    logic                       r_fwd;
    logic [bf3_pkg::PIX_W-1:0]  r_fwd_older, r_fwd_newer;

    assign o_older = r_fwd ? r_fwd_older : r_q_older;
    assign o_newer = r_fwd ? r_fwd_newer : r_q_newer;

    // the row shifts up: older takes what newer held, newer takes the new cell
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_older[r_addr] <= o_newer;
        end
        if (i_rd.en) begin
            r_q_older <= mem_older[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_newer[r_addr] <= i_wr_value;
        end
        if (i_rd.en) begin
            r_q_newer <= mem_newer[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_addr      <= i_rd.addr;
            r_fwd       <= i_wr_en && (i_rd.addr == r_addr);
            r_fwd_older <= o_newer;
            r_fwd_newer <= i_wr_value;
        end
    end

    a_fwd_newer: assert property (@(posedge i_clk)
        (i_wr_en && i_rd.en && i_rd.addr == r_addr) |=> (o_newer == $past(i_wr_value)))
        else $error("read after same-address write returned stale data");

endmodule

/* rtl/core/bf3_window.sv */
// 3x3 window register and the clipped neighborhood sum stage.
// Depends on bf3_pkg.
module bf3_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_valid,
    input  bf3_pkg::t_s1_info          i_s1,
    input  logic [bf3_pkg::PIX_W-1:0]  i_older,
    input  logic [bf3_pkg::PIX_W-1:0]  i_newer,
    input  logic                       i_out_free,
    output logic                       o_s1_take,
    output logic                       o_s3_valid,
    output bf3_pkg::t_sum              o_s3
);

    logic [2:0][2:0][bf3_pkg::PIX_W-1:0] r_win;
    logic                                r_s2_valid;
    bf3_pkg::t_emit                      r_s2_emit;
    logic                                r_s3_valid;
    bf3_pkg::t_sum                       r_s3, n_s3;
    logic                                s3_free, s2_free, s2_move;
    logic [2:0]                          row_use, col_use;
    logic [1:0]                          n_rows, n_cols;

    assign s3_free   = !r_s3_valid || i_out_free;
    assign s2_free   = !r_s2_valid || s3_free;
    assign s2_move   = r_s2_valid && s3_free;
    assign o_s1_take = i_s1_valid && s2_free;

    always_comb begin
        row_use = {r_s2_emit.has_down, 1'b1, r_s2_emit.has_up};
        col_use = {r_s2_emit.has_right, 1'b1, r_s2_emit.has_left};
        n_s3.sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_use[r] && col_use[c]) begin
                    n_s3.sum = n_s3.sum + bf3_pkg::SUM_W'(r_win[r][c]);
                end
            end
        end
        n_rows = 2'd1 + 2'(r_s2_emit.has_up) + 2'(r_s2_emit.has_down);
        n_cols = 2'd1 + 2'(r_s2_emit.has_left) + 2'(r_s2_emit.has_right);
        if (n_rows == 2'd3 && n_cols == 2'd3) begin
            n_s3.sel = bf3_pkg::DIV_BY9;
        end else if (n_rows == 2'd3 || n_cols == 2'd3) begin
            n_s3.sel = bf3_pkg::DIV_BY6;
        end else begin
            n_s3.sel = bf3_pkg::DIV_BY4;
        end
        n_s3.eof = r_s2_emit.eof;
    end

    // window shifts left on every item, firing or not
    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_older;
            r_win[1][2] <= i_newer;
            r_win[2][2] <= i_s1.is_push ? i_s1.value : '0;
            r_s2_emit   <= i_s1.emit;
        end
        if (s2_move) begin
            r_s3 <= n_s3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (o_s1_take) begin
                r_s2_valid <= i_s1.fire;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_s3_valid <= 1'b1;
            end else if (i_out_free) begin
                r_s3_valid <= 1'b0;
            end
        end
    end

    assign o_s3_valid = r_s3_valid;
    assign o_s3       = r_s3;

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !s3_free) |=> r_s2_valid)
        else $error("stalled window item was lost");

endmodule

/* rtl/core/bf3_div.sv */
// Divides the neighborhood sum by 4, 6 or 9 (shift or reciprocal multiply)
// and holds the result in the output register. Depends on bf3_pkg.
module bf3_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  bf3_pkg::t_sum              i_sum,
    input  logic                       i_ready,
    output logic                       o_free,
    output logic                       o_valid,
    output logic [bf3_pkg::PIX_W-1:0]  o_value,
    output logic                       o_eof
);

    logic                        r_valid;
    logic [bf3_pkg::PIX_W-1:0]   r_value;
    logic                        r_eof;
    logic [bf3_pkg::RECIP_W-1:0] recip;
    logic [bf3_pkg::PROD_W-1:0]  prod;
    logic [bf3_pkg::PIX_W-1:0]   quo;

    assign o_free = !r_valid || i_ready;

    always_comb begin
        recip = (i_sum.sel == bf3_pkg::DIV_BY9) ? bf3_pkg::RECIP_DIV9 : bf3_pkg::RECIP_DIV6;
        prod  = bf3_pkg::PROD_W'(i_sum.sum) * bf3_pkg::PROD_W'(recip);
        case (i_sum.sel)
            bf3_pkg::DIV_BY4: quo = bf3_pkg::PIX_W'(i_sum.sum >> 2);
            bf3_pkg::DIV_BY6,
            bf3_pkg::DIV_BY9: quo = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
            default:          quo = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_value <= quo;
            r_eof   <= i_sum.eof;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_eof   = r_eof;

endmodule
